/* rtl/nawe_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nawe_pkg
// shared sizes, the word descriptor and the buffer write port of the extractor
// ----------------------------------------------------------------------------
package nawe_pkg;

	localparam int MAX_WORD = 32;
	localparam int IDX_W    = $clog2(MAX_WORD);
	localparam int LEN_W    = $clog2(MAX_WORD + 1);
	localparam int ADDR_W   = IDX_W + 1;

	// one finished word waiting in a buffer bank
	typedef struct packed {
		logic             bank;
		logic [LEN_W-1:0] len;
		logic             trunc;
	} desc_t;

	// word buffer write port
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_t;

endpackage
`default_nettype wire

/* rtl/nawe_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nawe_front
// classifies document bytes, tracks line state and collects word characters
// ----------------------------------------------------------------------------
module nawe_front import nawe_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] text_byte,
	input  wire logic       end_of_input,
	output wr_t             wr,
	output logic            push,
	output desc_t           desc
);

	localparam logic [1:0] POS_MID  = 2'd0;
	localparam logic [1:0] POS_LINE = 2'd1;
	localparam logic [1:0] POS_DOC  = 2'd2;

	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_NUL   = 8'h00;

	logic [LEN_W-1:0] wlen_q, wlen_d;
	logic [1:0]       lpos_q, lpos_d;
	logic             req_q, req_d;
	logic             swl_q, swl_d;
	logic             inw_q, inw_d;
	logic             ovf_q, ovf_d;
	logic             bank_q;

	logic is_letter;
	logic is_word;

	assign is_letter = (text_byte >= 8'h61 && text_byte <= 8'h7a) ||
	                   (text_byte >= 8'h41 && text_byte <= 8'h5a);
	assign is_word   = is_letter || (text_byte == CH_APOS);

	always_comb begin
		wlen_d = wlen_q;
		lpos_d = lpos_q;
		req_d  = req_q;
		swl_d  = swl_q;
		inw_d  = inw_q;
		ovf_d  = ovf_q;
		push   = 1'b0;
		wr.en   = 1'b0;
		wr.addr = {bank_q, wlen_q[IDX_W-1:0]};
		wr.data = text_byte;
		desc.bank  = bank_q;
		desc.len   = wlen_q;
		desc.trunc = ovf_q;

		if (accept) begin
			// close the pending word when the byte is not part of it or input ends
			if (inw_q && (end_of_input || (!swl_q && !is_word))) begin
				if (wlen_q != '0 && !(req_q && !ovf_q && wlen_q == LEN_W'(2))) begin
					push  = 1'b1;
					req_d = 1'b0;
				end
				inw_d  = 1'b0;
				wlen_d = '0;
				ovf_d  = 1'b0;
				lpos_d = POS_MID;
			end

			if (end_of_input) begin
				swl_d  = 1'b0;
				req_d  = 1'b0;
				lpos_d = POS_DOC;
			end else if (swl_q) begin
				swl_d = 1'b0;
			end else if ((inw_q && is_word) || is_letter ||
			             (text_byte == CH_APOS && lpos_d == POS_MID)) begin
				// append, saturating at the buffer size
				inw_d  = 1'b1;
				lpos_d = POS_MID;
				if (wlen_d < LEN_W'(MAX_WORD)) begin
					wr.en  = 1'b1;
					wlen_d = wlen_d + LEN_W'(1);
				end else begin
					ovf_d = 1'b1;
				end
			end else if (text_byte == CH_NL) begin
				lpos_d = POS_LINE;
			end else if ((text_byte == CH_DOT || text_byte == CH_APOS) &&
			             lpos_d != POS_MID) begin
				req_d = 1'b1;
			end else if (text_byte == CH_NUL && lpos_d == POS_DOC) begin
				lpos_d = lpos_d;
			end else if (text_byte == CH_BSL) begin
				swl_d = 1'b1;
			end else begin
				lpos_d = POS_MID;
				req_d  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= '0;
			lpos_q <= POS_DOC;
			req_q  <= 1'b0;
			swl_q  <= 1'b0;
			inw_q  <= 1'b0;
			ovf_q  <= 1'b0;
			bank_q <= 1'b0;
		end else begin
			wlen_q <= wlen_d;
			lpos_q <= lpos_d;
			req_q  <= req_d;
			swl_q  <= swl_d;
			inw_q  <= inw_d;
			ovf_q  <= ovf_d;
			if (push) begin
				bank_q <= ~bank_q;
			end
		end
	end

`ifndef SYNTH
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (wlen_q == LEN_W'(MAX_WORD)))
		else $error("overflow flag set on a word that is not full");
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!inw_q |-> (wlen_q == '0 && !ovf_q))
		else $error("characters held outside a word");
`endif

endmodule
`default_nettype wire

/* rtl/nawe_desc_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nawe_desc_queue
// two-entry queue of finished words between the front and the back
// ----------------------------------------------------------------------------
module nawe_desc_queue import nawe_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire desc_t push_desc,
	input  wire logic  pop,
	output logic       head_valid,
	output desc_t      head,
	output logic       full
);

	desc_t      ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign head_valid = (cnt_q != 2'd0);
	assign head       = ent_q[rp_q];
	assign full       = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("word queue count out of range");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("word pushed into a full queue");
`endif

endmodule
`default_nettype wire

/* rtl/nawe_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nawe_back
// word buffer memory and the reader that plays words out one character each
// ----------------------------------------------------------------------------
module nawe_back import nawe_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire wr_t   wr,
	input  wire logic  head_valid,
	input  wire desc_t head,
	output logic       head_pop,
	output logic       out_valid,
	input  wire logic  out_pop,
	output logic [7:0] out_char,
	output logic       out_last,
	output logic       out_trunc
);

	logic [7:0]       mem [2**ADDR_W];
	logic [IDX_W-1:0] idx_q;
	logic             valid_q;
	logic             last_q;
	logic             trunc_q;
	logic [7:0]       rdata_q;

	logic rd_en;
	logic at_last;

	// output register is free or being emptied this cycle
	assign rd_en    = head_valid && (!valid_q || out_pop);
	assign at_last  = (LEN_W'(idx_q) + LEN_W'(1)) == head.len;
	assign head_pop = rd_en && at_last;

	assign out_valid = valid_q;
	assign out_char  = rdata_q;
	assign out_last  = last_q;
	assign out_trunc = trunc_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rdata_q <= mem[{head.bank, idx_q}];
			last_q  <= at_last;
			trunc_q <= head.trunc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				valid_q <= 1'b1;
				idx_q   <= at_last ? '0 : idx_q + IDX_W'(1);
			end else if (out_pop) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/nroff_aware_word_extractor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nroff_aware_word_extractor: one document byte per cycle in, one character out
// word output: the transaction carrying the byte (or end of input) that closes a word
//   queues it; its first character then enters the output register once that is free
// throughput: one byte per cycle unless full; one character per cycle out while
//   popped (single buffer read port); full rises while two finished words wait
// reset: arst_n clears all line and word state, the queue and the output register
// ----------------------------------------------------------------------------
module nroff_aware_word_extractor import nawe_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] text_byte,
	input  wire logic       end_of_input,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      word_char,
	output logic            word_last,
	output logic            word_truncated
);

	// front: classify and collect into the free bank of a two-bank buffer
	// back: play committed words out of the other bank
	wr_t   wr;
	logic  desc_push;
	desc_t desc;
	logic  head_valid;
	desc_t head;
	logic  head_pop;
	logic  out_valid;
	logic  accept;

	// while two words are queued both banks are busy, so input waits
	assign accept = push && !full;
	assign empty  = !out_valid;

	nawe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.text_byte    (text_byte),
		.end_of_input (end_of_input),
		.wr           (wr),
		.push         (desc_push),
		.desc         (desc)
	);

	// finished words, each naming its bank, length and truncation flag
	nawe_desc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (desc_push),
		.push_desc  (desc),
		.pop        (head_pop),
		.head_valid (head_valid),
		.head       (head),
		.full       (full)
	);

	// buffer memory read port feeds the output register directly
	nawe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.out_valid  (out_valid),
		.out_pop    (pop),
		.out_char   (word_char),
		.out_last   (word_last),
		.out_trunc  (word_truncated)
	);

endmodule
`default_nettype wire
